// ===== hw/rtl/box_filter_5x5_zero_pad_assert.svh =====
// Assertion macros shared by the checker files of the box filter.
// Both macros sample on the rising edge of clk and are held off while rst_n is low.
`ifndef BOX_FILTER_5X5_ZERO_PAD_ASSERT_SVH
`define BOX_FILTER_5X5_ZERO_PAD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BF5_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BF5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bf5_pkg.sv =====
package bf5_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int KERNEL_SIZE = 5;
    localparam int PIXEL_BITS  = 8;

    localparam int HALF  = KERNEL_SIZE / 2;
    localparam int LINES = KERNEL_SIZE - 1;

    localparam int DIM_BITS       = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PIX_FIELD_BITS = 8;
    localparam int SUM_BITS       = 13;
    localparam int OUT_ROW_BITS   = 11;
    localparam int OUT_COL_BITS   = 11;

    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT) + 1;
    localparam int CNT_ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int LAG_BITS    = $clog2(HALF * MAX_WIDTH + HALF + 1);
    localparam int CMP_BITS    = DIM_BITS + 1;
    localparam int COLSUM_BITS = $clog2(KERNEL_SIZE * ((1 << PIXEL_BITS) - 1) + 1);
    localparam int LINE_BITS   = LINES * PIXEL_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic [PIX_FIELD_BITS-1:0] pixel;
        logic                      flush;
    } pix_item_t;

    typedef struct packed {
        logic [SUM_BITS-1:0]     window_sum;
        logic [OUT_ROW_BITS-1:0] out_row;
        logic [OUT_COL_BITS-1:0] out_col;
        logic                    end_of_row;
        logic                    end_of_frame;
    } res_item_t;

    // A dimension of zero acts as one, and one above the maximum acts as the maximum.
    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] value,
        input logic [DIM_BITS-1:0] max_value
    );
        logic [DIM_BITS-1:0] result;
        begin
            if (value == '0)
            begin
                result = DIM_BITS'(1);
            end
            else if (value > max_value)
            begin
                result = max_value;
            end
            else
            begin
                result = value;
            end
            return result;
        end
    endfunction

endpackage

// ===== hw/rtl/bf5_ram.sv =====
module bf5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/box_filter_5x5_zero_pad.sv =====
// A result enters the output register after the item that completes its window has passed
// the stage-one and column-sum registers. Throughput: one item per cycle while results are
// taken; the line memory is read at one column and written back as the item leaves stage
// one, with forwarding when both touch the same column.
// Reset clears all counters and sets width and height to 2048. The line memory is not
// cleared; entries outside the image are masked to zero, so it needs no clearing pass.
module box_filter_5x5_zero_pad (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bf5_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bf5_pkg::DIM_BITS-1:0]        cfg_data,
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  bf5_pkg::pix_item_t                  pix_item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output bf5_pkg::res_item_t                  res_item
);

    localparam int K       = bf5_pkg::KERNEL_SIZE;
    localparam int P       = bf5_pkg::PIXEL_BITS;
    localparam int LINES   = bf5_pkg::LINES;
    localparam int HALF    = bf5_pkg::HALF;
    localparam int DIM     = bf5_pkg::DIM_BITS;
    localparam int CMP     = bf5_pkg::CMP_BITS;
    localparam int COLB    = bf5_pkg::COL_BITS;
    localparam int ROWB    = bf5_pkg::ROW_BITS;
    localparam int ORB     = bf5_pkg::CNT_ROW_BITS;
    localparam int LAGB    = bf5_pkg::LAG_BITS;
    localparam int CSB     = bf5_pkg::COLSUM_BITS;
    localparam int SUMB    = bf5_pkg::SUM_BITS;
    localparam int LINEB   = bf5_pkg::LINE_BITS;
    localparam logic [DIM-1:0]  MAX_W     = DIM'(bf5_pkg::MAX_WIDTH);
    localparam logic [DIM-1:0]  MAX_H     = DIM'(bf5_pkg::MAX_HEIGHT);
    localparam logic [LAGB-1:0] RESET_LAG = LAGB'(HALF * bf5_pkg::MAX_WIDTH + HALF);

    typedef struct packed {
        logic [bf5_pkg::OUT_ROW_BITS-1:0] out_row;
        logic [bf5_pkg::OUT_COL_BITS-1:0] out_col;
        logic                             end_of_row;
        logic                             end_of_frame;
    } meta_t;

    logic [DIM-1:0]  w_reg, w_next, h_reg, h_next;
    logic [LAGB-1:0] lag_reg, lag_next, pre_cnt_reg, pre_cnt_next;
    logic [COLB-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROWB-1:0] in_row_reg, in_row_next;
    logic [ORB-1:0]  out_row_reg, out_row_next;

    logic            cfg_fire, pix_fire, active, row_wrap, eor, eof, clear_cnt;
    logic [DIM-1:0]  cfg_clamped_w, cfg_clamped_h;
    logic [P-1:0]    px;
    logic [K-1:0]    cmask;
    meta_t           meta;

    logic            s1_valid_reg, s1_has_out_reg, s1_fwd_reg;
    logic [P-1:0]    s1_px_reg;
    logic [ROWB-1:0] s1_row_reg;
    logic [COLB-1:0] s1_col_reg;
    logic [K-1:0]    s1_cmask_reg;
    meta_t           s1_meta_reg;
    logic [LINEB-1:0] s1_fwd_data_reg;

    logic            s2_valid_reg, s2_has_out_reg;
    logic [K-1:0]    s2_cmask_reg;
    meta_t           s2_meta_reg;
    logic [CSB-1:0]  colsum_reg [K];

    logic            res_valid_reg;
    bf5_pkg::res_item_t res_item_reg;

    logic            out_free, s2_adv, s1_adv, s1_move;
    logic [LINEB-1:0] ram_rdata, line_word, wb_word;
    logic [P-1:0]    col_vals [K];
    logic [K-1:0]    row_ok;
    logic [CSB-1:0]  colsum;
    logic [SUMB-1:0] window_sum;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign out_free  = !res_valid_reg || res_ready;
    assign s2_adv    = !s2_valid_reg || !s2_has_out_reg || out_free;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign s1_move   = s1_valid_reg && s1_adv;
    assign pix_ready = s1_adv;
    assign pix_fire  = pix_valid && pix_ready;

    assign active   = (pre_cnt_reg == lag_reg);
    assign px       = pix_item.flush ? '0 : pix_item.pixel[P-1:0];
    assign row_wrap = (DIM'(in_col_reg) + DIM'(1)) >= w_reg;
    assign eor      = (DIM'(out_col_reg) == (w_reg - DIM'(1)));
    assign eof      = eor && (DIM'(out_row_reg) == (h_reg - DIM'(1)));

    assign cfg_clamped_w = bf5_pkg::clamp_dim(cfg_data, MAX_W);
    assign cfg_clamped_h = bf5_pkg::clamp_dim(cfg_data, MAX_H);

    always_comb
    begin
        for (int l = 0; l < K; l++)
        begin
            cmask[l] = ((CMP'(out_col_reg) + CMP'(l)) >= CMP'(HALF))
                    && ((CMP'(out_col_reg) + CMP'(l)) < (CMP'(w_reg) + CMP'(HALF)));
        end
    end

    always_comb
    begin
        meta.out_row      = bf5_pkg::OUT_ROW_BITS'(out_row_reg);
        meta.out_col      = bf5_pkg::OUT_COL_BITS'(out_col_reg);
        meta.end_of_row   = eor;
        meta.end_of_frame = eof;
    end

    always_comb
    begin
        w_next       = w_reg;
        h_next       = h_reg;
        lag_next     = lag_reg;
        pre_cnt_next = pre_cnt_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        clear_cnt    = 1'b0;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                bf5_pkg::REG_IMAGE_WIDTH:
                begin
                    w_next    = cfg_clamped_w;
                    lag_next  = LAGB'(HALF) * LAGB'(cfg_clamped_w) + LAGB'(HALF);
                    clear_cnt = 1'b1;
                end
                bf5_pkg::REG_IMAGE_HEIGHT:
                begin
                    h_next    = cfg_clamped_h;
                    clear_cnt = 1'b1;
                end
                default:
                begin
                    clear_cnt = 1'b0;
                end
            endcase
        end
        else if (pix_fire)
        begin
            if (!active)
            begin
                pre_cnt_next = pre_cnt_reg + LAGB'(1);
            end
            if (row_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROWB'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COLB'(1);
            end
            if (active)
            begin
                if (eor)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ORB'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COLB'(1);
                end
                clear_cnt = eof;
            end
        end
        if (clear_cnt)
        begin
            pre_cnt_next = '0;
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= MAX_W;
            h_reg       <= MAX_H;
            lag_reg     <= RESET_LAG;
            pre_cnt_reg <= '0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            lag_reg     <= lag_next;
            pre_cnt_reg <= pre_cnt_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Each entry holds the previous rows of one column, the most recent row in the low slot.
    bf5_ram #(
        .WIDTH(LINEB),
        .DEPTH(bf5_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata (wb_word),
        .re    (pix_fire),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= pix_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_px_reg       <= px;
            s1_row_reg      <= in_row_reg;
            s1_col_reg      <= in_col_reg;
            s1_has_out_reg  <= active;
            s1_meta_reg     <= meta;
            s1_cmask_reg    <= cmask;
            s1_fwd_reg      <= s1_valid_reg && (s1_col_reg == in_col_reg);
            s1_fwd_data_reg <= wb_word;
        end
    end

    assign line_word = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign wb_word   = {line_word[LINEB-P-1:0], s1_px_reg};

    always_comb
    begin
        col_vals[K-1] = s1_px_reg;
        for (int k = 0; k < LINES; k++)
        begin
            col_vals[k] = line_word[(LINES-1-k)*P +: P];
        end
        for (int k = 0; k < K; k++)
        begin
            row_ok[k] = ((CMP'(s1_row_reg) + CMP'(k)) >= CMP'(LINES))
                     && ((CMP'(s1_row_reg) + CMP'(k)) < (CMP'(h_reg) + CMP'(LINES)));
        end
        colsum = '0;
        for (int k = 0; k < K; k++)
        begin
            if (row_ok[k])
            begin
                colsum = colsum + CSB'(col_vals[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_has_out_reg <= s1_has_out_reg;
            s2_meta_reg    <= s1_meta_reg;
            s2_cmask_reg   <= s1_cmask_reg;
            for (int l = 0; l < K - 1; l++)
            begin
                colsum_reg[l] <= colsum_reg[l+1];
            end
            colsum_reg[K-1] <= colsum;
        end
    end

    always_comb
    begin
        window_sum = '0;
        for (int l = 0; l < K; l++)
        begin
            if (s2_cmask_reg[l])
            begin
                window_sum = window_sum + SUMB'(colsum_reg[l]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= s2_valid_reg && s2_has_out_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg && s2_has_out_reg)
        begin
            res_item_reg.window_sum   <= window_sum;
            res_item_reg.out_row      <= s2_meta_reg.out_row;
            res_item_reg.out_col      <= s2_meta_reg.out_col;
            res_item_reg.end_of_row   <= s2_meta_reg.end_of_row;
            res_item_reg.end_of_frame <= s2_meta_reg.end_of_frame;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

// ===== hw/rtl/bf5_checker.sv =====
`include "box_filter_5x5_zero_pad_assert.svh"

module bf5_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [bf5_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input logic [bf5_pkg::DIM_BITS-1:0]        cfg_data,
    input logic                                pix_valid,
    input logic                                pix_ready,
    input bf5_pkg::pix_item_t                  pix_item,
    input logic                                res_valid,
    input logic                                res_ready,
    input bf5_pkg::res_item_t                  res_item
);

    localparam int DIM = bf5_pkg::DIM_BITS;

    logic [DIM-1:0] w_seen_reg, w_seen_next, h_seen_reg, h_seen_next;
    logic           col_in_range, col_is_last, row_is_last;
    logic           eor_ok, eof_ok, res_wait, pix_wait;

    always_comb
    begin
        w_seen_next = w_seen_reg;
        h_seen_next = h_seen_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bf5_pkg::REG_IMAGE_WIDTH:
                begin
                    w_seen_next = bf5_pkg::clamp_dim(cfg_data, DIM'(bf5_pkg::MAX_WIDTH));
                end
                bf5_pkg::REG_IMAGE_HEIGHT:
                begin
                    h_seen_next = bf5_pkg::clamp_dim(cfg_data, DIM'(bf5_pkg::MAX_HEIGHT));
                end
                default:
                begin
                    w_seen_next = w_seen_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_seen_reg <= DIM'(bf5_pkg::MAX_WIDTH);
            h_seen_reg <= DIM'(bf5_pkg::MAX_HEIGHT);
        end
        else
        begin
            w_seen_reg <= w_seen_next;
            h_seen_reg <= h_seen_next;
        end
    end

    assign col_in_range = DIM'(res_item.out_col) < w_seen_reg;
    assign col_is_last  = DIM'(res_item.out_col) == (w_seen_reg - DIM'(1));
    assign row_is_last  = DIM'(res_item.out_row) == (h_seen_reg - DIM'(1));
    assign eor_ok       = res_item.end_of_row == col_is_last;
    assign eof_ok       = res_item.end_of_frame == (col_is_last && row_is_last);
    assign res_wait     = res_valid && !res_ready;
    assign pix_wait     = pix_valid && !pix_ready;

    // A stalled result keeps its contents until it is taken.
    `BF5_ASSERT_NEXT(a_res_hold, res_wait, res_valid && $stable(res_item), "result not held")

    // A waiting input item keeps its contents until it is taken.
    `BF5_ASSERT_NEXT(a_pix_hold, pix_wait, pix_valid && $stable(pix_item), "input not held")

    // Every result names a column inside the configured width.
    `BF5_ASSERT_NOW(a_col_range, res_valid, col_in_range, "result column beyond image width")

    // The end of a row is flagged exactly on the last column.
    `BF5_ASSERT_NOW(a_eor_col, res_valid, eor_ok, "end of row flag disagrees with column")

    // The end of the image is the end of a row on the last row.
    `BF5_ASSERT_NOW(a_eof_pos, res_valid, eof_ok, "end of frame flag disagrees with position")

endmodule

bind box_filter_5x5_zero_pad bf5_checker u_bf5_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_item  (pix_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
);

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_BITS       = bf5_pkg::DIM_BITS;
    localparam int CFG_INDEX_BITS = bf5_pkg::CFG_INDEX_BITS;
    localparam int PIX_FIELD_BITS = bf5_pkg::PIX_FIELD_BITS;
    localparam int PIXEL_BITS     = bf5_pkg::PIXEL_BITS;
    localparam int SUM_BITS       = bf5_pkg::SUM_BITS;
    localparam int OUT_ROW_BITS   = bf5_pkg::OUT_ROW_BITS;
    localparam int OUT_COL_BITS   = bf5_pkg::OUT_COL_BITS;
    localparam int HALF           = bf5_pkg::HALF;
    localparam int MAX_WIDTH      = bf5_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT     = bf5_pkg::MAX_HEIGHT;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [DIM_BITS-1:0]       cfg_data  = '0;
    logic                      pix_valid = 1'b0;
    logic                      pix_ready;
    bf5_pkg::pix_item_t        pix_item  = '0;
    logic                      res_valid;
    logic                      res_ready = 1'b0;
    bf5_pkg::res_item_t        res_item;

    box_filter_5x5_zero_pad dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_item  (pix_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    always #2 clk = ~clk;

    bf5_pkg::pix_item_t pixel_backlog[$];
    bf5_pkg::res_item_t sum_forecast[$];
    int        fed_count   = 0;
    int        taken_count = 0;
    int        idle_mode   = 0;
    int        err_count   = 0;
    int        stim_count  = 0;

    // Shadow of the block's registers and stream position.
    logic [DIM_BITS-1:0]   width_reg  = DIM_BITS'(2048);
    logic [DIM_BITS-1:0]   height_reg = DIM_BITS'(2048);
    int                    in_col     = 0;
    int                    in_row     = 0;
    int                    out_col    = 0;
    int                    out_row    = 0;
    logic [PIXEL_BITS-1:0] frame_px [int];

    function automatic int eff_dim(input logic [DIM_BITS-1:0] v, input int cap);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > cap)
        begin
            return cap;
        end
        return int'(v);
    endfunction

    function automatic int idle_pct(input bit receiver);
        if (idle_mode == 3)
        begin
            return 23;
        end
        if ((idle_mode == 1 && !receiver) || (idle_mode == 2 && receiver))
        begin
            return 72;
        end
        return 0;
    endfunction

    function automatic void clear_position();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        frame_px.delete();
    endfunction

    task automatic forecast_window(input bf5_pkg::pix_item_t it);
        int                    w;
        int                    h;
        int                    lag;
        int                    pos;
        int                    sum;
        logic [PIXEL_BITS-1:0] px;
        bf5_pkg::res_item_t    want;
        bit                    eor;
        bit                    eof;
        w   = eff_dim(width_reg, MAX_WIDTH);
        h   = eff_dim(height_reg, MAX_HEIGHT);
        px  = it.flush ? '0 : it.pixel;
        lag = HALF * w + HALF;
        pos = in_row * w + in_col;
        eof = 1'b0;
        frame_px[pos] = px;
        if (pos >= lag)
        begin
            sum = 0;
            for (int rr = out_row - HALF; rr <= out_row + HALF; rr++)
            begin
                for (int cc = out_col - HALF; cc <= out_col + HALF; cc++)
                begin
                    if (rr >= 0 && rr < h && cc >= 0 && cc < w)
                    begin
                        sum += frame_px[rr * w + cc];
                    end
                end
            end
            eor = (out_col == w - 1);
            eof = eor && (out_row == h - 1);
            want.window_sum   = SUM_BITS'(sum);
            want.out_row      = OUT_ROW_BITS'(out_row);
            want.out_col      = OUT_COL_BITS'(out_col);
            want.end_of_row   = eor;
            want.end_of_frame = eof;
            sum_forecast.push_back(want);
            if (eor)
            begin
                out_col = 0;
                out_row++;
            end
            else
            begin
                out_col++;
            end
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (eof)
        begin
            clear_position();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch(what, int'(got), int'(want));
        end
    endtask

    always @(posedge clk)
    begin : watch_items
        bf5_pkg::res_item_t want;
        if (rst_n && pix_valid && pix_ready)
        begin
            forecast_window(pix_item);
            taken_count++;
        end
        if (rst_n && res_valid && res_ready)
        begin
            if (sum_forecast.size() == 0)
            begin
                report_mismatch("result with nothing expected, window_sum",
                                int'(res_item.window_sum), 0);
            end
            else
            begin
                want = sum_forecast.pop_front();
                check_field("window_sum", 16'(res_item.window_sum), 16'(want.window_sum));
                check_field("out_row", 16'(res_item.out_row), 16'(want.out_row));
                check_field("out_col", 16'(res_item.out_col), 16'(want.out_col));
                check_field("end_of_row", 16'(res_item.end_of_row),
                            16'(want.end_of_row));
                check_field("end_of_frame", 16'(res_item.end_of_frame),
                            16'(want.end_of_frame));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!pix_valid || fed_count == taken_count)
        begin
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0))
            begin
                pix_item  <= pixel_backlog.pop_front();
                pix_valid <= 1'b1;
                fed_count++;
            end
            else
            begin
                pix_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        res_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [DIM_BITS-1:0] data);
        @(negedge clk);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (index == bf5_pkg::REG_IMAGE_WIDTH)
        begin
            width_reg = data;
        end
        else if (index == bf5_pkg::REG_IMAGE_HEIGHT)
        begin
            height_reg = data;
        end
        clear_position();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_item(input bit fl, input logic [PIX_FIELD_BITS-1:0] px);
        bf5_pkg::pix_item_t it;
        it.pixel = px;
        it.flush = fl;
        pixel_backlog.push_back(it);
        stim_count++;
    endtask

    function automatic logic [PIX_FIELD_BITS-1:0] pick_pixel(input int style);
        if (style == 1)
        begin
            return '1;
        end
        if (style == 2)
        begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return PIX_FIELD_BITS'($urandom_range(0, 255));
    endfunction

    task automatic queue_frame(input int w, input int h, input int flush_n,
                               input int style, input bit noisy);
        for (int i = 0; i < w * h; i++)
        begin
            push_item(noisy && $urandom_range(0, 15) == 0, pick_pixel(style));
        end
        for (int i = 0; i < flush_n; i++)
        begin
            push_item(!(noisy && $urandom_range(0, 7) == 0),
                      PIX_FIELD_BITS'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain();
        while (pixel_backlog.size() != 0 || fed_count != taken_count ||
               sum_forecast.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic run_phase(input logic [DIM_BITS-1:0] wv, input logic [DIM_BITS-1:0] hv,
                             input int mode, input int frames, input int style,
                             input bit noisy_ok);
        int w;
        int h;
        int st;
        int flush_n;
        bit noisy;
        idle_mode = mode;
        write_reg(bf5_pkg::REG_IMAGE_WIDTH, wv);
        write_reg(bf5_pkg::REG_IMAGE_HEIGHT, hv);
        w = eff_dim(wv, MAX_WIDTH);
        h = eff_dim(hv, MAX_HEIGHT);
        for (int f = 0; f < frames; f++)
        begin
            st = style;
            if (st < 0)
            begin
                st = $urandom_range(0, 9);
                st = (st < 2) ? st + 1 : 0;
            end
            noisy   = noisy_ok && $urandom_range(0, 3) == 0;
            flush_n = 2 * w + 2;
            if (noisy)
            begin
                flush_n = $urandom_range(0, 1) ? $urandom_range(0, 2 * w + 1)
                                               : 2 * w + 2 + $urandom_range(1, 5);
            end
            queue_frame(w, h, flush_n, st, noisy);
        end
        drain();
    endtask

    initial
    begin : main_sequence
        int                  phase_idx;
        logic [DIM_BITS-1:0] wv;
        logic [DIM_BITS-1:0] hv;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Items at the reset size never complete a window.
        push_item(1'b0, 8'hFF);
        push_item(1'b1, 8'hFF);
        push_item(1'b0, 8'h00);
        drain();

        write_reg(bf5_pkg::REG_IMAGE_WIDTH, DIM_BITS'(3));
        write_reg(bf5_pkg::REG_IMAGE_HEIGHT, DIM_BITS'(2));
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'hFF);
        push_item(1'b1, 8'hAA);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h01);
        repeat (8) push_item(1'b1, 8'hFF);
        push_item(1'b0, 8'h80);
        push_item(1'b0, 8'h40);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h01);
        push_item(1'b0, 8'h02);
        repeat (3) push_item(1'b0, 8'hFF);
        repeat (5) push_item(1'b1, 8'h55);
        repeat (2) push_item(1'b1, 8'h00);
        drain();

        run_phase(DIM_BITS'(0), DIM_BITS'(0), 0, 4, 0, 1'b0);

        // An oversized width acts as the maximum, so these items complete no window.
        idle_mode = 0;
        write_reg(bf5_pkg::REG_IMAGE_WIDTH, DIM_BITS'(4095));
        write_reg(bf5_pkg::REG_IMAGE_HEIGHT, DIM_BITS'(2));
        repeat (40) push_item(1'b0, 8'hFF);
        drain();

        // A single column with an oversized height, cut short by the next write.
        idle_mode = 2;
        write_reg(bf5_pkg::REG_IMAGE_WIDTH, DIM_BITS'(1));
        write_reg(bf5_pkg::REG_IMAGE_HEIGHT, DIM_BITS'(4095));
        repeat (200) push_item(1'b0, pick_pixel(0));
        drain();

        run_phase(DIM_BITS'(7), DIM_BITS'(6), 3, 2, 1, 1'b0);

        phase_idx = 0;
        while (stim_count < 1050 || phase_idx < 4)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                wv = '0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                wv = DIM_BITS'($urandom_range(13, 24));
            end
            else
            begin
                wv = DIM_BITS'($urandom_range(1, 12));
            end
            hv = DIM_BITS'($urandom_range(0, 9));
            run_phase(wv, hv, phase_idx % 4, $urandom_range(2, 4), -1, 1'b1);
            phase_idx++;
        end

        drain();
        if (err_count == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
